// ----- hdl/rmj_pkg.sv -----
// shared constants for the radar measurement jacobian block
`timescale 1ns / 1ps
`default_nettype none
package rmj_pkg;

   // default word format of the state and of the jacobian entries
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

endpackage
`default_nettype wire

// ----- hdl/rmj_mul.sv -----
// pipelined shift-add multiplier, one multiplier bit per stage, with side tag
`timescale 1ns / 1ps
`default_nettype none
module rmj_mul #(
   parameter int A_WIDTH   = 32,
   parameter int B_WIDTH   = 32,
   parameter int TAG_WIDTH = 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         vld_i,
   input  wire logic [A_WIDTH-1:0]           a_i,
   input  wire logic [B_WIDTH-1:0]           b_i,
   input  wire logic [TAG_WIDTH-1:0]         tag_i,
   output logic                              vld_o,
   output logic [A_WIDTH+B_WIDTH-1:0]        p_o,
   output logic [TAG_WIDTH-1:0]              tag_o
);

   localparam int PW = A_WIDTH + B_WIDTH;

   logic [A_WIDTH-1:0]   a_in     [B_WIDTH];
   logic [A_WIDTH-1:0]   a_ff     [B_WIDTH];
   logic [B_WIDTH-1:0]   b_in     [B_WIDTH];
   logic [B_WIDTH-1:0]   b_ff     [B_WIDTH];
   logic [PW-1:0]        acc_prev [B_WIDTH];
   logic [PW-1:0]        acc_in   [B_WIDTH];
   logic [PW-1:0]        acc_ff   [B_WIDTH];
   logic [TAG_WIDTH-1:0] tag_in   [B_WIDTH];
   logic [TAG_WIDTH-1:0] tag_ff   [B_WIDTH];
   logic [B_WIDTH-1:0]   vld_in;
   logic [B_WIDTH-1:0]   vld_ff;

   for (genvar g = 0; g < B_WIDTH; g++) begin : g_stage
      // stage inputs come from the ports or the stage before
      if (g == 0) begin : g_first
         assign a_in[g]     = a_i;
         assign b_in[g]     = b_i;
         assign tag_in[g]   = tag_i;
         assign vld_in[g]   = vld_i;
         assign acc_prev[g] = '0;
      end else begin : g_next
         assign a_in[g]     = a_ff[g-1];
         assign b_in[g]     = b_ff[g-1];
         assign tag_in[g]   = tag_ff[g-1];
         assign vld_in[g]   = vld_ff[g-1];
         assign acc_prev[g] = acc_ff[g-1];
      end

      // add the partial product of multiplier bit g
      assign acc_in[g] = acc_prev[g] + (b_in[g][g] ? (PW'(a_in[g]) << g) : PW'(0));

      // valid bit of the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_in[g];
         end
      end

      // payload of the stage
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[g]   <= a_in[g];
            b_ff[g]   <= b_in[g];
            acc_ff[g] <= acc_in[g];
            tag_ff[g] <= tag_in[g];
         end
      end
   end

   assign vld_o = vld_ff[B_WIDTH-1];
   assign p_o   = acc_ff[B_WIDTH-1];
   assign tag_o = tag_ff[B_WIDTH-1];

endmodule
`default_nettype wire

// ----- hdl/rmj_search.sv -----
// pipelined digit search: largest q with q*d <= r, or q*q*d <= r, one bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rmj_search #(
   parameter int D_WIDTH   = 64,
   parameter int R_WIDTH   = 96,
   parameter int Q_WIDTH   = 32,
   parameter bit SQUARE    = 1'b0,
   parameter int TAG_WIDTH = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 vld_i,
   input  wire logic [D_WIDTH-1:0]   d_i,
   input  wire logic [R_WIDTH-1:0]   r_i,
   input  wire logic [TAG_WIDTH-1:0] tag_i,
   output logic                      vld_o,
   output logic [Q_WIDTH-1:0]        q_o,
   output logic [TAG_WIDTH-1:0]      tag_o
);

   localparam int TW  = D_WIDTH + 2 * Q_WIDTH + 1;
   localparam int XW  = (R_WIDTH > TW) ? R_WIDTH : TW;
   localparam int QDW = D_WIDTH + Q_WIDTH;

   logic [D_WIDTH-1:0]   d_prev   [Q_WIDTH];
   logic [D_WIDTH-1:0]   d_ff     [Q_WIDTH];
   logic [R_WIDTH-1:0]   rem_prev [Q_WIDTH];
   logic [R_WIDTH-1:0]   rem_in   [Q_WIDTH];
   logic [R_WIDTH-1:0]   rem_ff   [Q_WIDTH];
   logic [Q_WIDTH-1:0]   q_prev   [Q_WIDTH];
   logic [Q_WIDTH-1:0]   q_in     [Q_WIDTH];
   logic [Q_WIDTH-1:0]   q_ff     [Q_WIDTH];
   logic [QDW-1:0]       qd_prev  [Q_WIDTH];
   logic [QDW-1:0]       qd_in    [Q_WIDTH];
   logic [QDW-1:0]       qd_ff    [Q_WIDTH];
   logic [XW-1:0]        term     [Q_WIDTH];
   logic [TAG_WIDTH-1:0] tag_prev [Q_WIDTH];
   logic [TAG_WIDTH-1:0] tag_ff   [Q_WIDTH];
   logic [Q_WIDTH-1:0]   take;
   logic [Q_WIDTH-1:0]   vld_prev;
   logic [Q_WIDTH-1:0]   vld_ff;

   for (genvar g = 0; g < Q_WIDTH; g++) begin : g_stage
      localparam int K = Q_WIDTH - 1 - g;

      // stage inputs come from the ports or the stage before
      if (g == 0) begin : g_first
         assign d_prev[g]   = d_i;
         assign rem_prev[g] = r_i;
         assign q_prev[g]   = '0;
         assign qd_prev[g]  = '0;
         assign tag_prev[g] = tag_i;
         assign vld_prev[g] = vld_i;
      end else begin : g_next
         assign d_prev[g]   = d_ff[g-1];
         assign rem_prev[g] = rem_ff[g-1];
         assign q_prev[g]   = q_ff[g-1];
         assign qd_prev[g]  = qd_ff[g-1];
         assign tag_prev[g] = tag_ff[g-1];
         assign vld_prev[g] = vld_ff[g-1];
      end

      // growth of q^e*d when bit K is set
      assign term[g] = SQUARE ? ((XW'(qd_prev[g]) << (K + 1)) + (XW'(d_prev[g]) << (2 * K)))
                              : (XW'(d_prev[g]) << K);
      assign take[g] = term[g] <= XW'(rem_prev[g]);

      // keep the remainder r - q^e*d and the running q*d
      assign rem_in[g] = take[g] ? R_WIDTH'(XW'(rem_prev[g]) - term[g]) : rem_prev[g];
      assign q_in[g]   = take[g] ? (q_prev[g] | (Q_WIDTH'(1) << K)) : q_prev[g];
      assign qd_in[g]  = take[g] ? (qd_prev[g] + (QDW'(d_prev[g]) << K)) : qd_prev[g];

      // valid bit of the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_prev[g];
         end
      end

      // payload of the stage
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[g]   <= d_prev[g];
            rem_ff[g] <= rem_in[g];
            q_ff[g]   <= q_in[g];
            qd_ff[g]  <= qd_in[g];
            tag_ff[g] <= tag_prev[g];
         end
      end
   end

   assign vld_o = vld_ff[Q_WIDTH-1];
   assign q_o   = q_ff[Q_WIDTH-1];
   assign tag_o = tag_ff[Q_WIDTH-1];

endmodule
`default_nettype wire

// ----- hdl/radar_measurement_jacobian_top.sv -----
// radar measurement jacobian: top level with input, product, combine and search pipelines
// pipeline: input register, bit-per-stage multipliers (DATA_WIDTH, 2*DATA_WIDTH and
//   3*DATA_WIDTH stages), a combine register, the DATA_WIDTH-stage quotient and root
//   search and an output register
// throughput: one request per cycle; a stalled result freezes the whole pipeline
// reset: synchronous, clears all valid bits, payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module radar_measurement_jacobian_top #(
   parameter int DATA_WIDTH = rmj_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmj_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // pos_x, pos_y, vel_x, vel_y
   input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy
   output logic [((6*DATA_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // zero_distance, saturated
   output logic [1:0]                                 rsp_tuser
);

   localparam int W      = DATA_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int OUT_TW = ((6 * DATA_WIDTH + 7) / 8) * 8;
   localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};

   // sign and magnitude to saturated two's complement, {sat, value}
   function automatic logic [W:0] enc(input logic neg, input logic [W-1:0] q);
      logic [W:0] r;
      if (!neg) begin
         r = (q >= HALF) ? {1'b1, MAXP} : {1'b0, q};
      end else begin
         r = (q > HALF) ? {1'b1, HALF} : {1'b0, W'(~q + W'(1))};
      end
      return r;
   endfunction

   logic en;
   logic [W-1:0] pos_x, pos_y, vel_x, vel_y;
   logic [W-1:0] apx_in, apy_in, avx_in, avy_in;

   // whole pipeline moves when the output register is free or drained
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign pos_x = req_tdata[W-1:0];
   assign pos_y = req_tdata[2*W-1:W];
   assign vel_x = req_tdata[3*W-1:2*W];
   assign vel_y = req_tdata[4*W-1:3*W];

   // magnitudes, the most negative value keeps its full size
   assign apx_in = pos_x[W-1] ? W'(~pos_x + W'(1)) : pos_x;
   assign apy_in = pos_y[W-1] ? W'(~pos_y + W'(1)) : pos_y;
   assign avx_in = vel_x[W-1] ? W'(~vel_x + W'(1)) : vel_x;
   assign avy_in = vel_y[W-1] ? W'(~vel_y + W'(1)) : vel_y;

   logic         in_vld_ff;
   logic [W-1:0] apx_ff, apy_ff, avx_ff, avy_ff;
   logic         spx_ff, spy_ff, s1_ff, s2_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         apx_ff <= apx_in;
         apy_ff <= apy_in;
         avx_ff <= avx_in;
         avy_ff <= avy_in;
         spx_ff <= pos_x[W-1];
         spy_ff <= pos_y[W-1];
         s1_ff  <= vel_x[W-1] ^ pos_y[W-1];
         s2_ff  <= !(vel_y[W-1] ^ pos_x[W-1]);
      end
   end

   // first products: px^2, py^2, vx*py, vy*px
   logic           l1_vld_a, l1_vld_b, l1_vld_c, l1_vld_d, l1_vld;
   logic [2*W-1:0] l1_px2, l1_py2, l1_a1, l1_a2;
   logic [W:0]     l1_tag_x, l1_tag_y;
   logic           l1_s1, l1_s2;

   rmj_mul #(.A_WIDTH(W), .B_WIDTH(W), .TAG_WIDTH(W + 1)) u_mul_px2 (
      .clock(clock), .reset(reset), .en(en), .vld_i(in_vld_ff),
      .a_i(apx_ff), .b_i(apx_ff), .tag_i({spx_ff, apx_ff}),
      .vld_o(l1_vld_a), .p_o(l1_px2), .tag_o(l1_tag_x));

   rmj_mul #(.A_WIDTH(W), .B_WIDTH(W), .TAG_WIDTH(W + 1)) u_mul_py2 (
      .clock(clock), .reset(reset), .en(en), .vld_i(in_vld_ff),
      .a_i(apy_ff), .b_i(apy_ff), .tag_i({spy_ff, apy_ff}),
      .vld_o(l1_vld_b), .p_o(l1_py2), .tag_o(l1_tag_y));

   rmj_mul #(.A_WIDTH(W), .B_WIDTH(W), .TAG_WIDTH(1)) u_mul_a1 (
      .clock(clock), .reset(reset), .en(en), .vld_i(in_vld_ff),
      .a_i(avx_ff), .b_i(apy_ff), .tag_i(s1_ff),
      .vld_o(l1_vld_c), .p_o(l1_a1), .tag_o(l1_s1));

   rmj_mul #(.A_WIDTH(W), .B_WIDTH(W), .TAG_WIDTH(1)) u_mul_a2 (
      .clock(clock), .reset(reset), .en(en), .vld_i(in_vld_ff),
      .a_i(avy_ff), .b_i(apx_ff), .tag_i(s2_ff),
      .vld_o(l1_vld_d), .p_o(l1_a2), .tag_o(l1_s2));

   assign l1_vld = l1_vld_a & l1_vld_b & l1_vld_c & l1_vld_d;

   // squared distance and cross term vx*py - vy*px in sign and magnitude
   logic [2*W-1:0] s_in, c_in;
   logic           sc_in;

   assign s_in = l1_px2 + l1_py2;

   always_comb begin
      priority if (l1_s1 == l1_s2) begin
         c_in  = l1_a1 + l1_a2;
         sc_in = l1_s1;
      end else if (l1_a1 >= l1_a2) begin
         c_in  = l1_a1 - l1_a2;
         sc_in = l1_s1;
      end else begin
         c_in  = l1_a2 - l1_a1;
         sc_in = l1_s2;
      end
   end

   logic           cmb_vld_ff;
   logic [2*W-1:0] s_ff, c_ff, px2_ff, py2_ff;
   logic           sc_ff, spx_c_ff, spy_c_ff;
   logic [W-1:0]   apx_c_ff, apy_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmb_vld_ff <= 1'b0;
      end else if (en) begin
         cmb_vld_ff <= l1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff     <= s_in;
         c_ff     <= c_in;
         sc_ff    <= sc_in;
         px2_ff   <= l1_px2;
         py2_ff   <= l1_py2;
         spx_c_ff <= l1_tag_x[W];
         apx_c_ff <= l1_tag_x[W-1:0];
         spy_c_ff <= l1_tag_y[W];
         apy_c_ff <= l1_tag_y[W-1:0];
      end
   end

   // second products: s^2, px*c, py*c
   logic           l2_vld_a, l2_vld_b, l2_vld_c, l2_vld;
   logic [4*W-1:0] l2_s2;
   logic [2*W-1:0] l2_s;
   logic [3*W-1:0] l2_nx, l2_ny;
   logic [3*W+1:0] l2_tag_x;
   logic [3*W:0]   l2_tag_y;

   rmj_mul #(.A_WIDTH(2 * W), .B_WIDTH(2 * W), .TAG_WIDTH(2 * W)) u_mul_s2 (
      .clock(clock), .reset(reset), .en(en), .vld_i(cmb_vld_ff),
      .a_i(s_ff), .b_i(s_ff), .tag_i(s_ff),
      .vld_o(l2_vld_a), .p_o(l2_s2), .tag_o(l2_s));

   rmj_mul #(.A_WIDTH(W), .B_WIDTH(2 * W), .TAG_WIDTH(3 * W + 2)) u_mul_nx (
      .clock(clock), .reset(reset), .en(en), .vld_i(cmb_vld_ff),
      .a_i(apx_c_ff), .b_i(c_ff), .tag_i({spx_c_ff, sc_ff, px2_ff, apx_c_ff}),
      .vld_o(l2_vld_b), .p_o(l2_nx), .tag_o(l2_tag_x));

   rmj_mul #(.A_WIDTH(W), .B_WIDTH(2 * W), .TAG_WIDTH(3 * W + 1)) u_mul_ny (
      .clock(clock), .reset(reset), .en(en), .vld_i(cmb_vld_ff),
      .a_i(apy_c_ff), .b_i(c_ff), .tag_i({spy_c_ff, py2_ff, apy_c_ff}),
      .vld_o(l2_vld_c), .p_o(l2_ny), .tag_o(l2_tag_y));

   assign l2_vld = l2_vld_a & l2_vld_b & l2_vld_c;

   // third products: s^3, (px*c)^2, (py*c)^2
   logic           l3_vld_a, l3_vld_b, l3_vld_c, l3_vld;
   logic [7*W-1:0] l3_s3_full;
   logic [6*W-1:0] l3_s3, l3_nx2, l3_ny2;
   logic [2*W-1:0] l3_s;
   logic [3*W+1:0] l3_tag_x;
   logic [3*W:0]   l3_tag_y;

   rmj_mul #(.A_WIDTH(4 * W), .B_WIDTH(3 * W), .TAG_WIDTH(2 * W)) u_mul_s3 (
      .clock(clock), .reset(reset), .en(en), .vld_i(l2_vld),
      .a_i(l2_s2), .b_i({{W{1'b0}}, l2_s}), .tag_i(l2_s),
      .vld_o(l3_vld_a), .p_o(l3_s3_full), .tag_o(l3_s));

   rmj_mul #(.A_WIDTH(3 * W), .B_WIDTH(3 * W), .TAG_WIDTH(3 * W + 2)) u_mul_nx2 (
      .clock(clock), .reset(reset), .en(en), .vld_i(l2_vld),
      .a_i(l2_nx), .b_i(l2_nx), .tag_i(l2_tag_x),
      .vld_o(l3_vld_b), .p_o(l3_nx2), .tag_o(l3_tag_x));

   rmj_mul #(.A_WIDTH(3 * W), .B_WIDTH(3 * W), .TAG_WIDTH(3 * W + 1)) u_mul_ny2 (
      .clock(clock), .reset(reset), .en(en), .vld_i(l2_vld),
      .a_i(l2_ny), .b_i(l2_ny), .tag_i(l2_tag_y),
      .vld_o(l3_vld_c), .p_o(l3_ny2), .tag_o(l3_tag_y));

   assign l3_vld = l3_vld_a & l3_vld_b & l3_vld_c;
   // s^3 is at most 2^(6W-3)
   assign l3_s3  = l3_s3_full[6*W-1:0];

   // unpack the carried fields
   logic           l3_spx, l3_spy, l3_sc, l3_zero;
   logic [2*W-1:0] l3_px2, l3_py2;
   logic [W-1:0]   l3_apx, l3_apy;

   assign l3_spx  = l3_tag_x[3*W+1];
   assign l3_sc   = l3_tag_x[3*W];
   assign l3_px2  = l3_tag_x[3*W-1:W];
   assign l3_apx  = l3_tag_x[W-1:0];
   assign l3_spy  = l3_tag_y[3*W];
   assign l3_py2  = l3_tag_y[3*W-1:W];
   assign l3_apy  = l3_tag_y[W-1:0];
   assign l3_zero = (l3_s == '0);

   // quotient and root searches, one entry each
   logic         q_vld_a, q_vld_b, q_vld_c, q_vld_d, q_vld_e, q_vld_f, q_vld;
   logic [W-1:0] q_rng_x, q_rng_y, q_brg_x, q_brg_y, q_rte_x, q_rte_y;
   logic [1:0]   t_rng_x;
   logic         t_rng_y, t_brg_x, t_brg_y, t_rte_x, t_rte_y;

   rmj_search #(.D_WIDTH(2 * W), .R_WIDTH(2 * W + 2 * F), .Q_WIDTH(W), .SQUARE(1'b1),
                .TAG_WIDTH(2)) u_rng_x (
      .clock(clock), .reset(reset), .en(en), .vld_i(l3_vld),
      .d_i(l3_s), .r_i({l3_px2, {(2*F){1'b0}}}), .tag_i({l3_zero, l3_spx}),
      .vld_o(q_vld_a), .q_o(q_rng_x), .tag_o(t_rng_x));

   rmj_search #(.D_WIDTH(2 * W), .R_WIDTH(2 * W + 2 * F), .Q_WIDTH(W), .SQUARE(1'b1),
                .TAG_WIDTH(1)) u_rng_y (
      .clock(clock), .reset(reset), .en(en), .vld_i(l3_vld),
      .d_i(l3_s), .r_i({l3_py2, {(2*F){1'b0}}}), .tag_i(l3_spy),
      .vld_o(q_vld_b), .q_o(q_rng_y), .tag_o(t_rng_y));

   rmj_search #(.D_WIDTH(2 * W), .R_WIDTH(W + 2 * F), .Q_WIDTH(W), .SQUARE(1'b0),
                .TAG_WIDTH(1)) u_brg_x (
      .clock(clock), .reset(reset), .en(en), .vld_i(l3_vld),
      .d_i(l3_s), .r_i({l3_apy, {(2*F){1'b0}}}), .tag_i(!l3_spy),
      .vld_o(q_vld_c), .q_o(q_brg_x), .tag_o(t_brg_x));

   rmj_search #(.D_WIDTH(2 * W), .R_WIDTH(W + 2 * F), .Q_WIDTH(W), .SQUARE(1'b0),
                .TAG_WIDTH(1)) u_brg_y (
      .clock(clock), .reset(reset), .en(en), .vld_i(l3_vld),
      .d_i(l3_s), .r_i({l3_apx, {(2*F){1'b0}}}), .tag_i(l3_spx),
      .vld_o(q_vld_d), .q_o(q_brg_y), .tag_o(t_brg_y));

   rmj_search #(.D_WIDTH(6 * W), .R_WIDTH(6 * W + 2 * F), .Q_WIDTH(W), .SQUARE(1'b1),
                .TAG_WIDTH(1)) u_rte_x (
      .clock(clock), .reset(reset), .en(en), .vld_i(l3_vld),
      .d_i(l3_s3), .r_i({l3_ny2, {(2*F){1'b0}}}), .tag_i(l3_spy ^ l3_sc),
      .vld_o(q_vld_e), .q_o(q_rte_x), .tag_o(t_rte_x));

   rmj_search #(.D_WIDTH(6 * W), .R_WIDTH(6 * W + 2 * F), .Q_WIDTH(W), .SQUARE(1'b1),
                .TAG_WIDTH(1)) u_rte_y (
      .clock(clock), .reset(reset), .en(en), .vld_i(l3_vld),
      .d_i(l3_s3), .r_i({l3_nx2, {(2*F){1'b0}}}), .tag_i(!(l3_spx ^ l3_sc)),
      .vld_o(q_vld_f), .q_o(q_rte_y), .tag_o(t_rte_y));

   assign q_vld = q_vld_a & q_vld_b & q_vld_c & q_vld_d & q_vld_e & q_vld_f;

   // signing, clipping and the zero distance case
   logic [W:0]        e_rng_x, e_rng_y, e_brg_x, e_brg_y, e_rte_x, e_rte_y;
   logic              sat_in, zero_in;
   logic [6*W-1:0]    data_in;

   assign e_rng_x = enc(t_rng_x[0], q_rng_x);
   assign e_rng_y = enc(t_rng_y, q_rng_y);
   assign e_brg_x = enc(t_brg_x, q_brg_x);
   assign e_brg_y = enc(t_brg_y, q_brg_y);
   assign e_rte_x = enc(t_rte_x, q_rte_x);
   assign e_rte_y = enc(t_rte_y, q_rte_y);
   assign zero_in = t_rng_x[1];

   always_comb begin
      if (zero_in) begin
         data_in = '0;
         sat_in  = 1'b0;
      end else begin
         data_in = {e_rte_y[W-1:0], e_rte_x[W-1:0], e_brg_y[W-1:0],
                    e_brg_x[W-1:0], e_rng_y[W-1:0], e_rng_x[W-1:0]};
         sat_in  = e_rng_x[W] | e_rng_y[W] | e_brg_x[W] | e_brg_y[W]
                 | e_rte_x[W] | e_rte_y[W];
      end
   end

   // output register
   logic           rsp_vld_ff;
   logic [6*W-1:0] rsp_data_ff;
   logic [1:0]     rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= q_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= data_in;
         rsp_user_ff <= {sat_in, zero_in};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = OUT_TW'(rsp_data_ff);
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ----- tb/tb_radar_measurement_jacobian_top.sv -----
// testbench for the radar measurement jacobian block, self-checking against a wide-integer predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_radar_measurement_jacobian_top;

   localparam int DW       = rmj_pkg::DATA_WIDTH_DEF;
   localparam int FB       = rmj_pkg::FRAC_BITS_DEF;
   localparam int REQ_W    = ((4*DW+7)/8)*8;
   localparam int RSP_W    = ((6*DW+7)/8)*8;
   localparam int N_RANDOM = 2000;
   localparam int LATENCY  = 7*DW+3;
   localparam int HOLDOFF  = 600;
   localparam int WATCHDOG = 4000;

   typedef logic [511:0] wide_type;
   typedef logic signed [DW-1:0] word_type;

   typedef struct packed {
      word_type range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy;
      logic     zero_distance, saturated;
   } jacobian_type;

   // jacobian predictor and queue of pending jacobians
   class jacobian_scoreboard;
      jacobian_type pending[$];
      int           errors = 0;

      // largest q with q (or q squared) times den not above num
      function automatic wide_type largest_quot(bit square, wide_type den, wide_type num);
         wide_type lo, hi, mid, t;
         lo = 0;
         hi = (wide_type'(1) << (DW-1)) + 1;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = square ? mid * mid * den : mid * den;
            if (t <= num) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      // apply sign and clip to the word range
      function automatic word_type clip(bit neg, wide_type mag, ref bit sat);
         wide_type half;
         half = wide_type'(1) << (DW-1);
         if (!neg) begin
            if (mag >= half) begin
               sat = 1;
               return word_type'(half - 1);
            end
            return word_type'(mag);
         end
         if (mag > half) begin
            sat = 1;
            mag = half;
         end
         return word_type'(-mag);
      endfunction

      function automatic wide_type magnitude(word_type v);
         return v[DW-1] ? wide_type'(-(65'(signed'(v)))) : wide_type'(unsigned'(v));
      endfunction

      function automatic jacobian_type predict(word_type px_s, word_type py_s,
                                               word_type vx_s, word_type vy_s);
         jacobian_type j;
         wide_type px, py, vx, vy, px2, py2, s, s3, a1, a2, c, n, scale;
         bit spx, spy, svx, svy, s1, s2, sc, sat;
         j = '0;
         sat = 0;
         spx = px_s[DW-1]; spy = py_s[DW-1]; svx = vx_s[DW-1]; svy = vy_s[DW-1];
         px = magnitude(px_s); py = magnitude(py_s);
         vx = magnitude(vx_s); vy = magnitude(vy_s);
         px2 = px * px;
         py2 = py * py;
         s = px2 + py2;
         if (s == 0) begin
            j.zero_distance = 1;
            return j;
         end
         scale = wide_type'(1) << (2*FB);
         s3 = s * s * s;
         // cross term vx*py - vy*px as sign and magnitude
         a1 = vx * py; s1 = svx ^ spy;
         a2 = vy * px; s2 = !(svy ^ spx);
         if (s1 == s2) begin
            c = a1 + a2; sc = s1;
         end else if (a1 >= a2) begin
            c = a1 - a2; sc = s1;
         end else begin
            c = a2 - a1; sc = s2;
         end
         j.range_dx   = clip(spx,  largest_quot(1, s, px2 * scale), sat);
         j.range_dy   = clip(spy,  largest_quot(1, s, py2 * scale), sat);
         j.bearing_dx = clip(!spy, largest_quot(0, s, py * scale), sat);
         j.bearing_dy = clip(spx,  largest_quot(0, s, px * scale), sat);
         n = py * c;
         j.rate_dx    = clip(spy ^ sc, largest_quot(1, s3, n * n * scale), sat);
         n = px * c;
         j.rate_dy    = clip(!(spx ^ sc), largest_quot(1, s3, n * n * scale), sat);
         j.saturated  = sat;
         return j;
      endfunction

      function void note_request(logic [REQ_W-1:0] d);
         pending.push_back(predict(d[0 +: DW], d[DW +: DW], d[2*DW +: DW], d[3*DW +: DW]));
      endfunction

      function void check_result(logic [RSP_W-1:0] d, logic [1:0] u);
         jacobian_type e, a;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result data=%h user=%b", $time, d, u);
            errors++;
            return;
         end
         e = pending.pop_front();
         a.range_dx = d[0 +: DW];       a.range_dy = d[DW +: DW];
         a.bearing_dx = d[2*DW +: DW];  a.bearing_dy = d[3*DW +: DW];
         a.rate_dx = d[4*DW +: DW];     a.rate_dy = d[5*DW +: DW];
         a.zero_distance = u[0];        a.saturated = u[1];
         if (a.range_dx !== e.range_dx)
            $display("%0t: range_dx exp %0d got %0d", $time, e.range_dx, a.range_dx);
         if (a.range_dy !== e.range_dy)
            $display("%0t: range_dy exp %0d got %0d", $time, e.range_dy, a.range_dy);
         if (a.bearing_dx !== e.bearing_dx)
            $display("%0t: bearing_dx exp %0d got %0d", $time, e.bearing_dx, a.bearing_dx);
         if (a.bearing_dy !== e.bearing_dy)
            $display("%0t: bearing_dy exp %0d got %0d", $time, e.bearing_dy, a.bearing_dy);
         if (a.rate_dx !== e.rate_dx)
            $display("%0t: rate_dx exp %0d got %0d", $time, e.rate_dx, a.rate_dx);
         if (a.rate_dy !== e.rate_dy)
            $display("%0t: rate_dy exp %0d got %0d", $time, e.rate_dy, a.rate_dy);
         if (a.zero_distance !== e.zero_distance)
            $display("%0t: zero_distance exp %b got %b", $time, e.zero_distance,
                     a.zero_distance);
         if (a.saturated !== e.saturated)
            $display("%0t: saturated exp %b got %b", $time, e.saturated, a.saturated);
         if (a !== e) errors++;
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;

   jacobian_scoreboard sb = new();
   int  accepted = 0;
   int  idle_cycles = 0;
   bit  holdoff_done = 0;

   radar_measurement_jacobian_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // request and result monitors, with a watchdog on silent cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tdata);
            accepted++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // one state field with bias toward extremes and tiny values
   function automatic word_type pick_field();
      case ($urandom_range(0, 7))
         0, 1, 2: return word_type'($urandom);
         3:       return word_type'($urandom_range(0, 3)) * ($urandom_range(0, 1) ? 1 : -1);
         4:       return word_type'($urandom_range(0, 1 << 20)) *
                         ($urandom_range(0, 1) ? 1 : -1);
         5:       return 0;
         6:       return $urandom_range(0, 1) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         default: return word_type'($urandom_range(0, 1 << 26)) *
                         ($urandom_range(0, 1) ? 1 : -1);
      endcase
   endfunction

   // offer one request and hold it until taken
   task automatic send_request(word_type px, word_type py, word_type vx, word_type vy);
      req_tdata  = {vy, vx, py, px};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic gap(int n);
      req_tvalid = 0;
      repeat (n) @(negedge clock);
   endtask

   // receiver stall pattern, with one long hold-off midway
   initial begin
      int mode;
      mode = 0;
      @(negedge clock);
      forever begin
         if (!holdoff_done && accepted >= 1000) begin
            rsp_tready = 0;
            repeat (HOLDOFF) @(negedge clock);
            holdoff_done = 1;
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0:       rsp_tready = 1;
            1:       rsp_tready = $urandom_range(0, 1);
            default: rsp_tready = ($urandom_range(0, 4) == 0);
         endcase
         @(negedge clock);
      end
   end

   initial begin
      word_type mx, mn;
      int burst;
      mx = {1'b0, {(DW-1){1'b1}}};
      mn = {1'b1, {(DW-1){1'b0}}};
      repeat (8) @(negedge clock);
      reset = 0;

      // directed: zero distance, extremes, single axes, tiny distances
      send_request(0, 0, 0, 0);
      send_request(0, 0, mx, mn);
      send_request(mx, mx, mx, mx);
      send_request(mn, mn, mn, mn);
      send_request(mn, mx, mx, mn);
      send_request(mx, mn, mn, mx);
      send_request(1, 0, 0, 0);
      send_request(0, 1, 0, 0);
      send_request(-1, 0, 5, -7);
      send_request(0, -1, mx, mx);
      send_request(1, 1, mn, mx);
      send_request(-1, 1, 1 << 16, -(1 << 16));
      send_request(1 << 16, 0, 0, 1 << 16);
      send_request(3 << 16, 4 << 16, 1 << 16, 2 << 16);
      send_request(-(3 << 16), 4 << 16, -(2 << 16), 1 << 16);
      send_request(mn, 0, mx, 0);
      send_request(0, mn, 0, mn);
      send_request(mx, 0, 0, mx);
      send_request(100, -100, 100, 100);
      send_request(1 << 30, 1 << 30, mn, 1);

      // pause until the pipeline has drained
      req_tvalid = 0;
      while (sb.pending.size() != 0) @(negedge clock);

      // random bursts with random gaps
      burst = 0;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 12));
         end
         burst--;
         send_request(pick_field(), pick_field(), pick_field(), pick_field());
      end
      req_tvalid = 0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
